[design/rpso_pkg.sv]
// ----------------------------------------------------------------------------
// rpso_pkg
// Shared types and constants for the RGB pixel stream operator.
// ----------------------------------------------------------------------------
package rpso_pkg;

    localparam int PIX_W      = 8;
    localparam int MODE_W     = 3;
    localparam int DIM_REG_W  = 13;
    localparam int OFS_REG_W  = 12;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // operation codes held in the mode register
    localparam logic [MODE_W-1:0] MODE_ROTATE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLACKOUT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CROP      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GRAYSCALE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONTRAST  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE          = 3'd0,
        REG_IMAGE_COLS    = 3'd1,
        REG_IMAGE_ROWS    = 3'd2,
        REG_CROP_LEFT     = 3'd3,
        REG_CROP_TOP      = 3'd4,
        REG_CROP_RIGHT    = 3'd5,
        REG_CROP_BOTTOM   = 3'd6,
        REG_CONTRAST_GAIN = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [DIM_REG_W-1:0]     image_cols;
        logic [DIM_REG_W-1:0]     image_rows;
        logic [OFS_REG_W-1:0]     crop_left;
        logic [OFS_REG_W-1:0]     crop_top;
        logic [DIM_REG_W-1:0]     crop_right;
        logic [DIM_REG_W-1:0]     crop_bottom;
        logic signed [GAIN_W-1:0] contrast_gain;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
        logic             status;
        logic             emit;
    } pix_res_t;

    // grayscale: floor(x/100) == (x * 5243) >> 19 for x < 25600
    localparam int GRAY_SUM_W  = 15;
    localparam int GRAY_PROD_W = 28;
    localparam int GRAY_RECIP  = 5243;
    localparam int GRAY_SHIFT  = 19;
    localparam int GRAY_WR     = 30;
    localparam int GRAY_WG     = 59;
    localparam int GRAY_WB     = 11;

    // contrast: floor(((2c - 255) * gain + 65280) / 512), clamped
    localparam int CON_NUM_W   = 27;
    localparam int CON_MID     = 255;
    localparam int CON_OFS     = 65280;
    localparam int CON_SHIFT   = 9;

endpackage

[design/rpso_cfg.sv]
// ----------------------------------------------------------------------------
// rpso_cfg
// Configuration register file, effective frame size and crop window check.
// ----------------------------------------------------------------------------
module rpso_cfg #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [rpso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpso_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rpso_pkg::cfg_t                   cfg,
    output logic [$clog2(MAX_DIM+1)-1:0]     cols_eff,
    output logic [$clog2(MAX_DIM+1)-1:0]     rows_eff,
    output logic                             crop_ok
);
    import rpso_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
    localparam logic [EW-1:0] MAX_X = EW'(MAX_DIM);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic [EW-1:0] cols_x, rows_x, cols_w, rows_w;
    logic [EW-1:0] left_x, top_x, right_x, bottom_x;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:          cfg_next.mode          = cfg_data[MODE_W-1:0];
                REG_IMAGE_COLS:    cfg_next.image_cols    = cfg_data[DIM_REG_W-1:0];
                REG_IMAGE_ROWS:    cfg_next.image_rows    = cfg_data[DIM_REG_W-1:0];
                REG_CROP_LEFT:     cfg_next.crop_left     = cfg_data[OFS_REG_W-1:0];
                REG_CROP_TOP:      cfg_next.crop_top      = cfg_data[OFS_REG_W-1:0];
                REG_CROP_RIGHT:    cfg_next.crop_right    = cfg_data[DIM_REG_W-1:0];
                REG_CROP_BOTTOM:   cfg_next.crop_bottom   = cfg_data[DIM_REG_W-1:0];
                REG_CONTRAST_GAIN: cfg_next.contrast_gain = $signed(cfg_data[GAIN_W-1:0]);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode          <= MODE_ROTATE;
            cfg_reg.image_cols    <= DIM_REG_W'(1);
            cfg_reg.image_rows    <= DIM_REG_W'(1);
            cfg_reg.crop_left     <= '0;
            cfg_reg.crop_top      <= '0;
            cfg_reg.crop_right    <= DIM_REG_W'(1);
            cfg_reg.crop_bottom   <= DIM_REG_W'(1);
            cfg_reg.contrast_gain <= GAIN_W'(256);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // zero acts as one, anything above MAX_DIM saturates
    always_comb begin
        cols_x   = EW'(cfg_reg.image_cols);
        rows_x   = EW'(cfg_reg.image_rows);
        cols_eff = (cols_x == '0) ? DW'(1) : (cols_x > MAX_X) ? DW'(MAX_DIM) : DW'(cols_x);
        rows_eff = (rows_x == '0) ? DW'(1) : (rows_x > MAX_X) ? DW'(MAX_DIM) : DW'(rows_x);
        cols_w   = EW'(cols_eff);
        rows_w   = EW'(rows_eff);
        left_x   = EW'(cfg_reg.crop_left);
        top_x    = EW'(cfg_reg.crop_top);
        right_x  = EW'(cfg_reg.crop_right);
        bottom_x = EW'(cfg_reg.crop_bottom);
        crop_ok  = (left_x < cols_w) && (top_x < rows_w) &&
                   (right_x > left_x) && (right_x <= cols_w) &&
                   (bottom_x > top_x) && (bottom_x <= rows_w);
    end

    assign cfg = cfg_reg;

endmodule

[design/rpso_pos.sv]
// ----------------------------------------------------------------------------
// rpso_pos
// Raster column/row counters; advance once per accepted pixel.
// ----------------------------------------------------------------------------
module rpso_pos #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           advance,
    input  logic [$clog2(MAX_DIM+1)-1:0]   cols_eff,
    input  logic [$clog2(MAX_DIM+1)-1:0]   rows_eff,
    output logic [$clog2(MAX_DIM)-1:0]     col,
    output logic [$clog2(MAX_DIM)-1:0]     row,
    output logic                           frame_end
);
    import rpso_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [DW-1:0]    col_inc, row_inc;
    logic             col_wrap, row_wrap;

    always_comb begin
        col_inc  = DW'(col_reg) + DW'(1);
        row_inc  = DW'(row_reg) + DW'(1);
        // ">=" so a counter left out of range by a smaller size wraps next
        col_wrap = (col_inc >= cols_eff);
        row_wrap = (row_inc >= rows_eff);
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : CNT_W'(row_inc);
            end else begin
                col_next = CNT_W'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col       = col_reg;
    assign row       = row_reg;
    assign frame_end = col_wrap && row_wrap;

endmodule

[design/rpso_alu.sv]
// ----------------------------------------------------------------------------
// rpso_alu
// Per-pixel point operation selected by the mode register.
// ----------------------------------------------------------------------------
module rpso_alu #(
    parameter int MAX_DIM = 4096
) (
    input  rpso_pkg::cfg_t                    cfg,
    input  logic                              crop_ok,
    input  logic [$clog2(MAX_DIM+1)-1:0]      cols_eff,
    input  logic [$clog2(MAX_DIM+1)-1:0]      rows_eff,
    input  logic [$clog2(MAX_DIM)-1:0]        col,
    input  logic [$clog2(MAX_DIM)-1:0]        row,
    input  logic                              frame_end,
    input  logic [rpso_pkg::PIX_W-1:0]        red,
    input  logic [rpso_pkg::PIX_W-1:0]        green,
    input  logic [rpso_pkg::PIX_W-1:0]        blue,
    output rpso_pkg::pix_res_t                res
);
    import rpso_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
    localparam logic signed [CON_NUM_W-1:0] CON_OFS_S = CON_NUM_W'(CON_OFS);
    localparam logic signed [9:0]            CON_MID_S = 10'(CON_MID);

    function automatic logic [PIX_W-1:0] contrast_chan(
        input logic [PIX_W-1:0]        c,
        input logic signed [GAIN_W-1:0] gain
    );
        logic signed [9:0]           d;
        logic signed [CON_NUM_W-1:0] num;
        d   = $signed({1'b0, c, 1'b0}) - CON_MID_S;
        num = CON_NUM_W'(d * gain) + CON_OFS_S;
        if (num[CON_NUM_W-1]) begin
            return '0;
        end else if (|num[CON_NUM_W-2:CON_SHIFT+PIX_W]) begin
            return '1;
        end else begin
            return num[CON_SHIFT +: PIX_W];
        end
    endfunction

    logic [DW:0]              cols_p1, rows_p1;
    logic                     in_black;
    logic [EW-1:0]            col_x, row_x;
    logic                     in_win, win_last;
    logic [GRAY_SUM_W-1:0]    gsum;
    logic [GRAY_PROD_W-1:0]   gprod;
    logic [PIX_W-1:0]         gray;

    always_comb begin
        // top-right quadrant, halves rounded up
        cols_p1  = (DW+1)'(cols_eff) + (DW+1)'(1);
        rows_p1  = (DW+1)'(rows_eff) + (DW+1)'(1);
        in_black = (DW'(col) >= cols_p1[DW:1]) && (DW'(row) < rows_p1[DW:1]);

        col_x    = EW'(col);
        row_x    = EW'(row);
        in_win   = (col_x >= EW'(cfg.crop_left)) && (col_x < EW'(cfg.crop_right)) &&
                   (row_x >= EW'(cfg.crop_top)) && (row_x < EW'(cfg.crop_bottom));
        win_last = (col_x + EW'(1) == EW'(cfg.crop_right)) &&
                   (row_x + EW'(1) == EW'(cfg.crop_bottom));

        gsum  = GRAY_SUM_W'(red) * GRAY_SUM_W'(GRAY_WR) +
                GRAY_SUM_W'(green) * GRAY_SUM_W'(GRAY_WG) +
                GRAY_SUM_W'(blue) * GRAY_SUM_W'(GRAY_WB);
        gprod = GRAY_PROD_W'(gsum) * GRAY_PROD_W'(GRAY_RECIP);
        gray  = gprod[GRAY_SHIFT +: PIX_W];

        res.red    = red;
        res.green  = green;
        res.blue   = blue;
        res.last   = frame_end;
        res.status = 1'b0;
        res.emit   = 1'b1;

        case (cfg.mode)
            MODE_ROTATE: begin
                res.red   = green;
                res.green = blue;
                res.blue  = red;
            end
            MODE_BLACKOUT: begin
                if (in_black) begin
                    res.red   = '0;
                    res.green = '0;
                    res.blue  = '0;
                end
            end
            MODE_CROP: begin
                if (!crop_ok) begin
                    res.red    = '0;
                    res.green  = '0;
                    res.blue   = '0;
                    res.status = 1'b1;
                end else if (in_win) begin
                    res.last = win_last;
                end else begin
                    res.emit = 1'b0;
                end
            end
            MODE_GRAYSCALE: begin
                res.red   = gray;
                res.green = gray;
                res.blue  = gray;
            end
            MODE_CONTRAST: begin
                res.red   = contrast_chan(red, cfg.contrast_gain);
                res.green = contrast_chan(green, cfg.contrast_gain);
                res.blue  = contrast_chan(blue, cfg.contrast_gain);
            end
            default: begin
                res.status = 1'b0;
            end
        endcase
    end

endmodule

[design/rgb_pixel_stream_operator.sv]
// ----------------------------------------------------------------------------
// rgb_pixel_stream_operator
// Raster RGB point operations: rotate, blackout, crop, grayscale, contrast.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  ---------+-----------+---------------------------------------------------
//  s_       | in        | one pixel: tdata = red, green, blue
//  m_       | out       | one result pixel (none for pixels cropped away)
//  cfg_     | in        | register write: cfg_index selects, cfg_data value
//
//  One pixel per clock sustained while m_tready stays high; each result passes
//  the input register, then the result register after the operation.
//  s_tready drops only when both registers are full and m_tready is low.
//  Reset is synchronous: counters restart at column 0, row 0, registers
//  return to their defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module rgb_pixel_stream_operator #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // red_in, green_in, blue_in

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // red_out, green_out, blue_out
    output logic                             m_tlast,   // frame_last
    output logic                             m_tuser,   // status

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rpso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpso_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rpso_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);

    cfg_t             cfg;
    logic [DW-1:0]    cols_eff, rows_eff;
    logic             crop_ok;
    logic [CNT_W-1:0] col, row;
    logic             frame_end;
    pix_res_t         res;

    logic             accept, s1_en, out_en;
    logic             s1_valid_reg, s1_valid_next;
    logic             m_valid_reg, m_valid_next;

    logic [PIX_W-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [CNT_W-1:0] s1_col_reg, s1_row_reg;
    logic             s1_end_reg;

    logic [23:0]      m_data_reg;
    logic             m_last_reg, m_user_reg;

    assign cfg_ready = 1'b1;

    rpso_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .cols_eff  (cols_eff),
        .rows_eff  (rows_eff),
        .crop_ok   (crop_ok)
    );

    rpso_pos #(.MAX_DIM(MAX_DIM)) u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .cols_eff  (cols_eff),
        .rows_eff  (rows_eff),
        .col       (col),
        .row       (row),
        .frame_end (frame_end)
    );

    rpso_alu #(.MAX_DIM(MAX_DIM)) u_alu (
        .cfg       (cfg),
        .crop_ok   (crop_ok),
        .cols_eff  (cols_eff),
        .rows_eff  (rows_eff),
        .col       (s1_col_reg),
        .row       (s1_row_reg),
        .frame_end (s1_end_reg),
        .red       (s1_red_reg),
        .green     (s1_green_reg),
        .blue      (s1_blue_reg),
        .res       (res)
    );

    always_comb begin
        out_en        = !m_valid_reg || m_tready;
        s1_en         = !s1_valid_reg || out_en;
        accept        = s_tvalid && s1_en;
        s1_valid_next = s1_en ? s_tvalid : s1_valid_reg;
        // a cropped-away pixel leaves stage 1 without producing a result
        m_valid_next  = out_en ? (s1_valid_reg && res.emit) : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_red_reg   <= s_tdata[7:0];
            s1_green_reg <= s_tdata[15:8];
            s1_blue_reg  <= s_tdata[23:16];
            s1_col_reg   <= col;
            s1_row_reg   <= row;
            s1_end_reg   <= frame_end;
        end
        if (out_en && s1_valid_reg) begin
            m_data_reg <= {res.blue, res.green, res.red};
            m_last_reg <= res.last;
            m_user_reg <= res.status;
        end
    end

    assign s_tready = s1_en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // a bad crop window always yields a black pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("status set with nonzero color");

    // outside crop mode every pixel leaving stage 1 becomes a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && out_en && (cfg.mode != MODE_CROP)) |=> m_tvalid)
        else $error("result lost outside crop mode");

    // an empty input register must always take a new pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg |-> s_tready)
        else $error("input stalled with empty stage");

endmodule

[tb/rpso_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpso_result_checker
// Watches the pixel, result and register-write channels of the RGB pixel
// stream operator. Keeps its own copy of the registers and the column/row
// counters, predicts the result of every accepted pixel, and compares each
// result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rpso_result_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // red_in, green_in, blue_in

    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [23:0]                      m_tdata,   // red_out, green_out, blue_out
    input  logic                             m_tlast,   // frame_last
    input  logic                             m_tuser,   // status

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rpso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpso_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                               mismatches,
    output int                               outstanding
);
    import rpso_pkg::*;

    localparam int MAX_REPORTS = 60;

    cfg_t     shadow;
    int       col_pos;
    int       row_pos;
    pix_res_t expected_pixels[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // size registers of zero act as 1, oversize acts as MAX_DIM
    function automatic int frame_dim(logic [DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] stretch(logic [PIX_W-1:0] c, int gain);
        int num;
        num = (2 * int'(c) - 255) * gain + 65280;
        if (num < 0) return '0;
        if (num / 512 > 255) return 8'd255;
        return 8'(num / 512);
    endfunction

    function automatic pix_res_t operate(logic [PIX_W-1:0] r, g, b);
        int       cols;
        int       rows;
        int       gray;
        int       gain;
        logic     window_ok;
        pix_res_t res;
        cols       = frame_dim(shadow.image_cols);
        rows       = frame_dim(shadow.image_rows);
        res.red    = r;
        res.green  = g;
        res.blue   = b;
        res.last   = (col_pos + 1 >= cols) && (row_pos + 1 >= rows);
        res.status = 1'b0;
        res.emit   = 1'b1;
        case (shadow.mode)
            MODE_ROTATE: begin
                res.red   = g;
                res.green = b;
                res.blue  = r;
            end
            MODE_BLACKOUT: begin
                if (col_pos >= (cols + 1) / 2 && row_pos < (rows + 1) / 2) begin
                    res.red   = '0;
                    res.green = '0;
                    res.blue  = '0;
                end
            end
            MODE_CROP: begin
                window_ok = shadow.crop_left < cols && shadow.crop_top < rows &&
                            shadow.crop_right > shadow.crop_left &&
                            shadow.crop_right <= cols &&
                            shadow.crop_bottom > shadow.crop_top &&
                            shadow.crop_bottom <= rows;
                if (!window_ok) begin
                    res.red    = '0;
                    res.green  = '0;
                    res.blue   = '0;
                    res.status = 1'b1;
                end else if (col_pos >= shadow.crop_left && col_pos < shadow.crop_right &&
                             row_pos >= shadow.crop_top && row_pos < shadow.crop_bottom) begin
                    res.last = (col_pos + 1 == shadow.crop_right) &&
                               (row_pos + 1 == shadow.crop_bottom);
                end else begin
                    res.emit = 1'b0;
                end
            end
            MODE_GRAYSCALE: begin
                gray      = (30 * r + 59 * g + 11 * b) / 100;
                res.red   = 8'(gray);
                res.green = 8'(gray);
                res.blue  = 8'(gray);
            end
            MODE_CONTRAST: begin
                gain      = $signed(shadow.contrast_gain);
                res.red   = stretch(r, gain);
                res.green = stretch(g, gain);
                res.blue  = stretch(b, gain);
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin : track
        pix_res_t want;
        pix_res_t res;
        int       cols;
        int       rows;
        if (!aresetn) begin
            shadow.mode          = MODE_ROTATE;
            shadow.image_cols    = 1;
            shadow.image_rows    = 1;
            shadow.crop_left     = 0;
            shadow.crop_top      = 0;
            shadow.crop_right    = 1;
            shadow.crop_bottom   = 1;
            shadow.contrast_gain = 16'sd256;
            col_pos = 0;
            row_pos = 0;
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result transaction with no pixel pending, tdata",
                                    m_tdata, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[7:0] !== want.red)
                        report_mismatch("red_out", m_tdata[7:0], want.red);
                    if (m_tdata[15:8] !== want.green)
                        report_mismatch("green_out", m_tdata[15:8], want.green);
                    if (m_tdata[23:16] !== want.blue)
                        report_mismatch("blue_out", m_tdata[23:16], want.blue);
                    if (m_tlast !== want.last)
                        report_mismatch("frame_last", m_tlast, want.last);
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                end
            end
            if (s_tvalid && s_tready) begin
                res = operate(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
                if (res.emit) expected_pixels.push_back(res);
                // counters wrap with >= so an out-of-range position wraps at once
                cols = frame_dim(shadow.image_cols);
                rows = frame_dim(shadow.image_rows);
                if (col_pos + 1 >= cols) begin
                    col_pos = 0;
                    row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
                end else begin
                    col_pos = col_pos + 1;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_MODE:          shadow.mode          = cfg_data[MODE_W-1:0];
                    REG_IMAGE_COLS:    shadow.image_cols    = cfg_data[DIM_REG_W-1:0];
                    REG_IMAGE_ROWS:    shadow.image_rows    = cfg_data[DIM_REG_W-1:0];
                    REG_CROP_LEFT:     shadow.crop_left     = cfg_data[OFS_REG_W-1:0];
                    REG_CROP_TOP:      shadow.crop_top      = cfg_data[OFS_REG_W-1:0];
                    REG_CROP_RIGHT:    shadow.crop_right    = cfg_data[DIM_REG_W-1:0];
                    REG_CROP_BOTTOM:   shadow.crop_bottom   = cfg_data[DIM_REG_W-1:0];
                    REG_CONTRAST_GAIN: shadow.contrast_gain = cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

[tb/tb_rgb_pixel_stream_operator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_pixel_stream_operator
// Drives pixels and register writes into the operator: a short directed pass
// over every mode, field extremes and the crop/size corner cases, then random
// frames with random settings. Both stream sides idle at random; the result
// side holds off once for a long stretch. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_rgb_pixel_stream_operator;
    import rpso_pkg::*;

    localparam int FRAME_MAX     = 4096;
    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_PIXELS = 1000;

    // modes without an operation of their own: pixel passes unchanged
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [23:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int hold_reqs   = 0;
    int sender_calm = 0;
    int idle_cycles = 0;

    always #(HALF_PERIOD) aclk = ~aclk;

    rgb_pixel_stream_operator #(
        .MAX_DIM   (FRAME_MAX)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rpso_result_checker #(
        .MAX_DIM     (FRAME_MAX)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog: ends the run after too many cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall per transaction, calm stretches, one long hold
    initial begin : result_sink
        int stall;
        int hold_seen;
        int calm;
        hold_seen = 0;
        calm      = 0;
        @(posedge aresetn);
        forever begin
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                stall     = HOLD_CYCLES;
            end else if (calm > 0) begin
                calm--;
                stall = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                calm  = $urandom_range(10, 40);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
            end
            if (stall > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
                @(negedge aclk) m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        int width;
        case (idx)
            REG_MODE:                    width = MODE_W;
            REG_CROP_LEFT, REG_CROP_TOP: width = OFS_REG_W;
            REG_CONTRAST_GAIN:           width = GAIN_W;
            default:                     width = DIM_REG_W;
        endcase
        // junk in the bits above the register must be ignored
        if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
            value = value | (CFG_DATA_W'($urandom) << width);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk) cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [MODE_W-1:0] op, logic [DIM_REG_W-1:0] cols, rows,
                             logic [OFS_REG_W-1:0] crop_l, crop_t,
                             logic [DIM_REG_W-1:0] crop_r, crop_b,
                             logic [GAIN_W-1:0] gain);
        write_reg(REG_MODE, CFG_DATA_W'(op));
        write_reg(REG_IMAGE_COLS, CFG_DATA_W'(cols));
        write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(rows));
        write_reg(REG_CROP_LEFT, CFG_DATA_W'(crop_l));
        write_reg(REG_CROP_TOP, CFG_DATA_W'(crop_t));
        write_reg(REG_CROP_RIGHT, CFG_DATA_W'(crop_r));
        write_reg(REG_CROP_BOTTOM, CFG_DATA_W'(crop_b));
        write_reg(REG_CONTRAST_GAIN, gain);
    endtask

    // returns at the rising edge of the pixel transaction, tvalid still high
    task automatic push_pixel(logic [PIX_W-1:0] red, green, blue);
        int gap;
        if (sender_calm > 0) begin
            sender_calm--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            sender_calm = $urandom_range(10, 40);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
        end
        if (gap > 0) begin
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic push_random_pixel();
        if ($urandom_range(0, 7) == 0)
            push_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00,
                       $urandom_range(0, 1) ? 8'hFF : 8'h00,
                       $urandom_range(0, 1) ? 8'hFF : 8'h00);
        else
            push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // stop offering, wait for every predicted result, then let cropped pixels clear
    task automatic drain_results();
        @(negedge aclk) s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin : stimulus
        int                   phase;
        int                   sent;
        int                   count;
        int                   col_span;
        int                   row_span;
        logic [MODE_W-1:0]    op;
        logic [DIM_REG_W-1:0] cols;
        logic [DIM_REG_W-1:0] rows;
        logic [DIM_REG_W-1:0] crop_r;
        logic [DIM_REG_W-1:0] crop_b;
        logic [OFS_REG_W-1:0] crop_l;
        logic [OFS_REG_W-1:0] crop_t;
        logic [GAIN_W-1:0]    gain;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: 1x1 frame, rotate, every pixel ends a frame
        push_pixel(8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'hA5, 8'h5A, 8'h0F);
        push_pixel(8'h01, 8'h80, 8'hFE);
        drain_results();

        // blackout on an odd width: quadrant starts at ceil(cols/2)
        configure(MODE_BLACKOUT, 3, 2, 0, 0, 1, 1, 16'd256);
        repeat (6) push_pixel(8'hFF, 8'h80, 8'h7F);
        drain_results();

        // crop window wider than the frame is invalid
        configure(MODE_CROP, 3, 2, 0, 0, 4, 2, 16'd256);
        repeat (2) push_random_pixel();
        drain_results();

        // valid window at the bottom-right corner, counters carry over
        configure(MODE_CROP, 3, 2, 1, 1, 3, 2, 16'd256);
        repeat (4) push_random_pixel();
        drain_results();

        configure(MODE_GRAYSCALE, 3, 2, 1, 1, 3, 2, 16'd256);
        push_pixel(8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'h00, 8'h00, 8'hFF);
        drain_results();

        configure(MODE_CONTRAST, 3, 2, 1, 1, 3, 2, 16'h8000);
        push_pixel(8'hFF, 8'h00, 8'h80);
        drain_results();
        configure(MODE_CONTRAST, 3, 2, 1, 1, 3, 2, 16'h7FFF);
        push_pixel(8'hFF, 8'h00, 8'h7F);
        drain_results();
        configure(MODE_CONTRAST, 3, 2, 1, 1, 3, 2, 16'h0000);
        push_pixel(8'hFF, 8'h00, 8'h80);
        drain_results();

        configure(MODE_SPARE_FIRST, 3, 2, 1, 1, 3, 2, 16'd256);
        push_pixel(8'h12, 8'h34, 8'h56);
        drain_results();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE_LAST));
        push_pixel(8'hFE, 8'hDC, 8'hBA);
        drain_results();

        // zero width acts as 1, oversize height acts as the maximum
        configure(MODE_ROTATE, 0, 8191, 0, 0, 1, 1, 16'd256);
        repeat (2) push_random_pixel();
        drain_results();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 7) == 0)
                op = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            else
                op = MODE_W'($urandom_range(MODE_ROTATE, MODE_CONTRAST));

            case ($urandom_range(0, 15))
                0: begin
                    cols = $urandom_range(0, 1) ? 13'd4096
                                                : DIM_REG_W'($urandom_range(4097, 8191));
                    rows = DIM_REG_W'($urandom_range(1, 3));
                end
                1: begin
                    cols = DIM_REG_W'($urandom_range(1, 2));
                    rows = $urandom_range(0, 1) ? 13'd4096
                                                : DIM_REG_W'($urandom_range(4097, 8191));
                end
                2: begin
                    cols = DIM_REG_W'($urandom_range(0, 4));
                    rows = (cols == 0) ? DIM_REG_W'($urandom_range(0, 4)) : 13'd0;
                end
                default: begin
                    cols = DIM_REG_W'($urandom_range(1, 8));
                    rows = DIM_REG_W'($urandom_range(1, 8));
                end
            endcase
            col_span = (cols == 0) ? 1 : (cols > FRAME_MAX ? FRAME_MAX : cols);
            row_span = (rows == 0) ? 1 : (rows > FRAME_MAX ? FRAME_MAX : rows);

            if ($urandom_range(0, 3) != 0) begin
                crop_l = OFS_REG_W'($urandom_range(0, col_span - 1));
                crop_r = DIM_REG_W'($urandom_range(crop_l + 1, col_span));
                crop_t = OFS_REG_W'($urandom_range(0, row_span - 1));
                crop_b = DIM_REG_W'($urandom_range(crop_t + 1, row_span));
            end else begin
                case ($urandom_range(0, 2))
                    0:       crop_l = '0;
                    1:       crop_l = '1;
                    default: crop_l = OFS_REG_W'($urandom_range(0, 7));
                endcase
                case ($urandom_range(0, 2))
                    0:       crop_t = '1;
                    1:       crop_t = 12'($urandom);
                    default: crop_t = OFS_REG_W'($urandom_range(0, 7));
                endcase
                case ($urandom_range(0, 3))
                    0:       crop_r = '0;
                    1:       crop_r = '1;
                    2:       crop_r = 13'd4096;
                    default: crop_r = DIM_REG_W'($urandom_range(0, 9));
                endcase
                case ($urandom_range(0, 2))
                    0:       crop_b = '0;
                    1:       crop_b = 13'($urandom);
                    default: crop_b = DIM_REG_W'($urandom_range(0, 9));
                endcase
            end

            case ($urandom_range(0, 5))
                0:       gain = 16'h8000;
                1:       gain = 16'h7FFF;
                2:       gain = 16'h0000;
                3:       gain = 16'd256;
                4:       gain = GAIN_W'($urandom_range(128, 1024));
                default: gain = 16'($urandom);
            endcase

            count = $urandom_range(20, 80);
            // long receiver hold: every pixel yields a result so the block backs up
            if (phase == 2) begin
                op    = MODE_GRAYSCALE;
                count = 80;
            end

            configure(op, cols, rows, crop_l, crop_t, crop_r, crop_b, gain);
            if (phase == 2) hold_reqs++;

            for (int i = 0; i < count; i++) begin
                // pause mid-frame until the results have caught up
                if (phase == 3 && i == count / 2) drain_results();
                push_random_pixel();
            end
            sent += count;
            drain_results();
            phase++;
        end

        drain_results();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
design/rpso_pkg.sv
design/rpso_cfg.sv
design/rpso_pos.sv
design/rpso_alu.sv
design/rgb_pixel_stream_operator.sv
tb/rpso_result_checker.sv
tb/tb_rgb_pixel_stream_operator.sv
